>>> design/srs_pkg.sv
// Shared constants and types for the sonar ranger scheduler with spike filter.
// No dependencies; used by srs_measure and the top level.
package srs_pkg;

	localparam int MAX_RANGERS = 8;
	localparam int ADC_BITS    = 10;

	localparam int IDX_W    = $clog2(MAX_RANGERS);
	localparam int CNT_W    = 4;
	localparam int SCALE_W  = 14;
	localparam int RAW_W    = 14;
	localparam int MM_W     = 15;
	localparam int MARGIN_W = 14;
	localparam int MASK_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [SCALE_W-1:0] SCALE_SHORT = SCALE_W'(13005);
	localparam logic [SCALE_W-1:0] SCALE_LONG  = SCALE_W'(10240);
	localparam logic [CNT_W-1:0]   WAIT_SHORT  = CNT_W'(2);
	localparam logic [CNT_W-1:0]   WAIT_LONG   = CNT_W'(4);
	localparam logic [CNT_W-1:0]   SETTLE_RESET = CNT_W'(10);
	localparam logic [MM_W-1:0]    RAW_RESET   = MM_W'(32000);
	localparam logic signed [MM_W-1:0] NONE_MM = -MM_W'(1000);
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(500);

	typedef logic [MM_W-1:0]          raw_mm_t;
	typedef logic signed [MM_W-1:0]   acc_mm_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGERS_IN_USE  = 3'd0,
		CFG_SPIKE_MARGIN_MM = 3'd1,
		CFG_TYPE_MASK       = 3'd2,
		CFG_TRIGGER_MASK    = 3'd3
	} cfg_reg_t;

	// Verdict of the scaling and spike check for one reading
	typedef struct packed {
		logic [RAW_W-1:0] raw_mm;
		logic             accept;
	} meas_t;

endpackage

>>> design/srs_measure.sv
// Scales one converter sample to millimetres and runs the spike check.
// Depends on srs_pkg.
module srs_measure (
	input  logic [srs_pkg::ADC_BITS-1:0] sample,
	input  logic                         type_long,
	input  srs_pkg::raw_mm_t             last_raw,
	input  srs_pkg::acc_mm_t             acc_mm,
	input  logic [srs_pkg::MARGIN_W-1:0] margin,
	output srs_pkg::meas_t               meas
);

	localparam int PROD_W = srs_pkg::ADC_BITS + srs_pkg::SCALE_W;
	localparam int DIFF_W = srs_pkg::MM_W + 2;

	logic [srs_pkg::SCALE_W-1:0]  scale;
	logic [PROD_W-1:0]            prod;
	logic [srs_pkg::RAW_W-1:0]    raw;
	logic signed [DIFF_W-1:0]     raw_s;
	logic signed [DIFF_W-1:0]     d_raw;
	logic signed [DIFF_W-1:0]     d_acc;
	logic [DIFF_W-1:0]            a_raw;
	logic [DIFF_W-1:0]            a_acc;
	logic [DIFF_W-1:0]            margin_x;

	// Scale to millimetres: sample * full scale >> ADC_BITS
	assign scale = type_long ? srs_pkg::SCALE_LONG : srs_pkg::SCALE_SHORT;
	assign prod  = PROD_W'(sample) * PROD_W'(scale);
	assign raw   = prod[srs_pkg::ADC_BITS +: srs_pkg::RAW_W];

	// Distances to the last raw and last accepted readings
	assign raw_s = $signed(DIFF_W'(raw));
	assign d_raw = raw_s - $signed(DIFF_W'(last_raw));
	assign d_acc = raw_s - DIFF_W'(acc_mm);
	assign a_raw = d_raw[DIFF_W-1] ? DIFF_W'(-d_raw) : DIFF_W'(d_raw);
	assign a_acc = d_acc[DIFF_W-1] ? DIFF_W'(-d_acc) : DIFF_W'(d_acc);
	assign margin_x = DIFF_W'(margin);

	assign meas.raw_mm = raw;
	assign meas.accept = (a_raw < margin_x) || (a_acc < margin_x);

endmodule

>>> design/sonar_ranger_scheduler_spike_filter.sv
// Top level: tick scheduler, per-ranger history and result register.
// Depends on srs_pkg and srs_measure.
//
//  channel | signals                                  | direction | transaction
//  in      | in_valid, in_stall, adc_sample           | in        | one tick with a sample
//  out     | out_valid, out_stall, measured .. filt.  | out       | one result per tick
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | one register write
//
// A tick enters the input register, is handled against the scheduler state and
// ranger history, and lands in the result register; one tick per cycle is
// sustained while the output does not stall. The per-tick loop is one
// 10x14 multiply plus two subtract/compare paths. Reset restores settle count
// 10, schedule step 0 and every ranger's history at once. An output stall holds
// the result register and backs up into in_stall only when the input register
// is full and cannot move.
module sonar_ranger_scheduler_spike_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [srs_pkg::ADC_BITS-1:0]      adc_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              measured,
	output logic [2:0]                        read_index,
	output logic [2:0]                        trigger_index,
	output logic                              trigger_pulse,
	output logic [13:0]                       raw_range_mm,
	output logic                              accepted,
	output logic signed [14:0]                filtered_range_mm,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IW = srs_pkg::IDX_W;
	localparam int CW = srs_pkg::CNT_W;

	// configuration registers
	logic [CW-1:0]                rangers_q;
	logic [srs_pkg::MARGIN_W-1:0] margin_q;
	logic [srs_pkg::MASK_W-1:0]   type_mask_q;
	logic [srs_pkg::MASK_W-1:0]   trig_mask_q;

	// scheduler and history state
	logic [CW-1:0]       settle_q;
	logic [CW-1:0]       step_q;
	srs_pkg::raw_mm_t    last_raw_q [srs_pkg::MAX_RANGERS];
	srs_pkg::acc_mm_t    acc_mm_q   [srs_pkg::MAX_RANGERS];

	// input stage
	logic                         valid_s1;
	logic [srs_pkg::ADC_BITS-1:0] sample_s1;

	// result register
	logic                      out_valid_q;
	logic                      measured_q;
	logic [2:0]                read_idx_q;
	logic [2:0]                trig_idx_q;
	logic                      trig_pulse_q;
	logic [13:0]               raw_q;
	logic                      accepted_q;
	logic signed [14:0]        filt_q;

	logic          out_free;
	logic          advance;
	logic          in_take;
	logic          settling;
	logic [CW-1:0] n_eff;
	logic [CW-1:0] step0;
	logic [CW-1:0] step_next;
	logic [CW-1:0] step_inc;
	logic [IW-1:0] rd;
	logic [IW-1:0] tr;
	logic          type_long;
	srs_pkg::meas_t meas;
	srs_pkg::acc_mm_t acc_new;

	assign cfg_ready = 1'b1;

	// Handshakes: input register moves when the result register can take it
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Clamp ranger count into 1..MAX_RANGERS
	always_comb begin
		if (rangers_q == '0) begin
			n_eff = CW'(1);
		end else if (rangers_q > CW'(srs_pkg::MAX_RANGERS)) begin
			n_eff = CW'(srs_pkg::MAX_RANGERS);
		end else begin
			n_eff = rangers_q;
		end
	end

	// Schedule: ranger 0 alternates with rangers 1..n-1
	always_comb begin
		step0     = step_q;
		step_inc  = '0;
		step_next = step_q;
		rd        = '0;
		tr        = '0;
		if (n_eff > CW'(1)) begin
			if ((CW'(step_q >> 1) + CW'(1)) >= n_eff) begin
				step0 = '0;
			end
			if (step0[0] == 1'b0) begin
				tr = IW'((step0 >> 1) + CW'(1));
			end else begin
				rd = IW'((step0 >> 1) + CW'(1));
			end
			step_inc  = step0 + CW'(1);
			step_next = ((CW'(step_inc >> 1) + CW'(1)) >= n_eff) ? '0 : step_inc;
		end
	end

	assign settling  = settle_q != '0;
	assign type_long = type_mask_q[rd];

	srs_measure u_measure (
		.sample    (sample_s1),
		.type_long (type_long),
		.last_raw  (last_raw_q[rd]),
		.acc_mm    (acc_mm_q[rd]),
		.margin    (margin_q),
		.meas      (meas)
	);

	assign acc_new = meas.accept ? srs_pkg::acc_mm_t'(meas.raw_mm) : acc_mm_q[rd];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rangers_q   <= CW'(1);
			margin_q    <= srs_pkg::MARGIN_RESET;
			type_mask_q <= '0;
			trig_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srs_pkg::CFG_RANGERS_IN_USE:  rangers_q   <= cfg_data[CW-1:0];
				srs_pkg::CFG_SPIKE_MARGIN_MM: margin_q    <= cfg_data[srs_pkg::MARGIN_W-1:0];
				srs_pkg::CFG_TYPE_MASK:       type_mask_q <= cfg_data[srs_pkg::MASK_W-1:0];
				srs_pkg::CFG_TRIGGER_MASK:    trig_mask_q <= cfg_data[srs_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= adc_sample;
		end
	end

	// Advance scheduler and ranger history once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= srs_pkg::SETTLE_RESET;
			step_q   <= '0;
			for (int i = 0; i < srs_pkg::MAX_RANGERS; i++) begin
				last_raw_q[i] <= srs_pkg::RAW_RESET;
				acc_mm_q[i]   <= srs_pkg::NONE_MM;
			end
		end else if (advance) begin
			if (settling) begin
				settle_q <= settle_q - CW'(1);
			end else begin
				settle_q       <= type_long ? srs_pkg::WAIT_LONG : srs_pkg::WAIT_SHORT;
				step_q         <= step_next;
				last_raw_q[rd] <= srs_pkg::raw_mm_t'(meas.raw_mm);
				acc_mm_q[rd]   <= acc_new;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload; settle ticks report all zeros
	always_ff @(posedge clk) begin
		if (advance) begin
			if (settling) begin
				measured_q   <= 1'b0;
				read_idx_q   <= '0;
				trig_idx_q   <= '0;
				trig_pulse_q <= 1'b0;
				raw_q        <= '0;
				accepted_q   <= 1'b0;
				filt_q       <= '0;
			end else begin
				measured_q   <= 1'b1;
				read_idx_q   <= 3'(rd);
				trig_idx_q   <= 3'(tr);
				trig_pulse_q <= trig_mask_q[tr];
				raw_q        <= meas.raw_mm;
				accepted_q   <= meas.accept;
				filt_q       <= acc_new;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign measured          = measured_q;
	assign read_index        = read_idx_q;
	assign trigger_index     = trig_idx_q;
	assign trigger_pulse     = trig_pulse_q;
	assign raw_range_mm      = raw_q;
	assign accepted          = accepted_q;
	assign filtered_range_mm = filt_q;

endmodule
